/* rtl/tcf_pkg.sv */
// Package for the tilt complementary filter core: widths, register indexes,
// fixed-point scaling constants and the CORDIC arctangent table.
// Used by tilt_complementary_filter_core; depends on nothing else.
package tcf_pkg;

    // Algorithm constants
    localparam int CORDIC_STEPS   = 16;   // range 8 to 24
    localparam int ROLL_FRAC_BITS = 12;   // range 6 to 16

    // Field widths
    localparam int GYRO_W    = 17;
    localparam int ACCEL_W   = 16;
    localparam int ROLL_W    = 21;
    localparam int SPEED_W   = 7;
    localparam int WEIGHT_W  = 16;
    localparam int BAND_W    = 20;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED  = 3'd4;

    localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RST  = 16'd58982;
    localparam logic [WEIGHT_W-1:0] ACCEL_WEIGHT_RST = 16'd6554;
    localparam logic [WEIGHT_W-1:0] TIME_STEP_RST    = 16'd655;
    localparam logic [BAND_W-1:0]   DEAD_BAND_RST    = 20'd4096;
    localparam logic [SPEED_W-1:0]  DRIVE_SPEED_RST  = 7'd40;
    localparam logic [SPEED_W-1:0]  SPEED_MAX        = 7'd100;

    // Shared multiplier: signed 26 x signed 17
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACCU_W  = PROD_W + 2;

    // Gyro increment: product has 24 fraction bits
    localparam int GYRO_SHIFT = 24 - ROLL_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] GYRO_HALF = PROD_W'(1) <<< (GYRO_SHIFT - 1);

    // CORDIC angle is degrees Q16
    localparam int Z_W       = 25;
    localparam int ANG_SHIFT = 16 - ROLL_FRAC_BITS;
    localparam logic signed [Z_W-1:0] ANG_HALF =
        (ANG_SHIFT == 0) ? Z_W'(0) : (Z_W'(1) <<< (ANG_SHIFT - 1));

    // Blend result is a Q16 weighted sum
    localparam int BLEND_SHIFT = 16;
    localparam logic signed [ACCU_W-1:0] BLEND_HALF = ACCU_W'(32768);

    // Square root: (ay^2 + az^2) << 16 fits 48 bits, two bits per step
    localparam int SQ_W       = 32;
    localparam int RAD_W      = SQ_W + 16;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (RAD_W - 2);

    // CORDIC vector registers and step counter
    localparam int CX_W       = 27;
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [ROLL_W-1:0] ROLL_MAX = {1'b0, {(ROLL_W-1){1'b1}}};
    localparam logic signed [ROLL_W-1:0] ROLL_MIN = {1'b1, {(ROLL_W-1){1'b0}}};

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic signed [Z_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:  val = 25'sd2949120;
            5'd1:  val = 25'sd1740967;
            5'd2:  val = 25'sd919879;
            5'd3:  val = 25'sd466945;
            5'd4:  val = 25'sd234379;
            5'd5:  val = 25'sd117304;
            5'd6:  val = 25'sd58666;
            5'd7:  val = 25'sd29335;
            5'd8:  val = 25'sd14668;
            5'd9:  val = 25'sd7334;
            5'd10: val = 25'sd3667;
            5'd11: val = 25'sd1833;
            5'd12: val = 25'sd917;
            5'd13: val = 25'sd458;
            5'd14: val = 25'sd229;
            5'd15: val = 25'sd115;
            5'd16: val = 25'sd57;
            5'd17: val = 25'sd29;
            5'd18: val = 25'sd14;
            5'd19: val = 25'sd7;
            5'd20: val = 25'sd4;
            5'd21: val = 25'sd2;
            5'd22: val = 25'sd1;
            default: val = 25'sd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/tilt_complementary_filter_core.sv */
// Tilt complementary filter core: gyro integration, accelerometer roll by
// integer square root and vectoring CORDIC, weighted blend and motor decision.
// Depends on tcf_pkg.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata: gyro_rate, accel_x/y/z
//  m_*       out        m_tvalid/m_tready   m_tdata: roll and motor decision
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A sample runs through the whole sequence before the next beat can be taken;
// the 24 two-bit steps of the square root and the CORDIC steps dominate its
// duration, and a single 26 x 17 multiplier serves all five products in turn.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next sample may be taken meanwhile. A result that
// finds the output register still full holds the sequencer in its last step.
// Reset is asynchronous, clears the roll and held direction and reloads the registers.

module tilt_complementary_filter_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [16:0] gyro_rate, [32:17] accel_x, [48:33] accel_y, [64:49] accel_z,
    // [71:65] zero
    input  logic [tcf_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [20:0] roll_angle, [21] motor_enable, [22] direction_forward,
    // [29:23] motor_speed, [31:30] zero
    output logic [tcf_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_SQY   = 4'd1;
    localparam logic [ST_W-1:0] S_SQZ   = 4'd2;
    localparam logic [ST_W-1:0] S_RATE  = 4'd3;
    localparam logic [ST_W-1:0] S_ROOT  = 4'd4;
    localparam logic [ST_W-1:0] S_CINIT = 4'd5;
    localparam logic [ST_W-1:0] S_CORD  = 4'd6;
    localparam logic [ST_W-1:0] S_GMUL  = 4'd7;
    localparam logic [ST_W-1:0] S_AMUL  = 4'd8;
    localparam logic [ST_W-1:0] S_SUM   = 4'd9;
    localparam logic [ST_W-1:0] S_SAT   = 4'd10;

    localparam int A_EXT = tcf_pkg::MUL_A_W - tcf_pkg::ACCEL_W;

    // Control state
    logic [ST_W-1:0]                     state_reg, state_next;
    logic [tcf_pkg::STEP_W-1:0]          cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [tcf_pkg::ROLL_W-1:0]   roll_est_reg, roll_est_next;
    logic                                dir_reg, dir_next;
    logic [tcf_pkg::WEIGHT_W-1:0]        gyro_weight_reg, accel_weight_reg, time_step_reg;
    logic [tcf_pkg::BAND_W-1:0]          dead_band_reg;
    logic [tcf_pkg::SPEED_W-1:0]         drive_speed_reg;

    // Datapath registers
    logic signed [tcf_pkg::GYRO_W-1:0]   gyro_reg;
    logic signed [tcf_pkg::ACCEL_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [tcf_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [tcf_pkg::ACCU_W-1:0]   acc_reg, acc_next;
    logic [tcf_pkg::RAD_W-1:0]           rad_reg, rad_next;
    logic [tcf_pkg::RAD_W-1:0]           root_reg, root_next;
    logic [tcf_pkg::RAD_W-1:0]           bit_reg, bit_next;
    logic signed [tcf_pkg::CX_W-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [tcf_pkg::Z_W-1:0]      cz_reg, cz_next;
    logic                                zero_reg, zero_next;
    logic signed [tcf_pkg::MUL_A_W-1:0]  gyro_roll_reg, gyro_roll_next;
    logic signed [tcf_pkg::Z_W-1:0]      acc_roll_reg, acc_roll_next;
    logic [tcf_pkg::OUT_DATA_W-1:0]      out_data_reg, out_data_next;

    // Combinational helpers
    logic                                mul_en;
    logic signed [tcf_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [tcf_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [tcf_pkg::ACCU_W-1:0]   prod_ext;
    logic signed [tcf_pkg::ACCU_W-1:0]   sq_sum;
    logic [tcf_pkg::RAD_W:0]             trial;
    logic signed [tcf_pkg::PROD_W-1:0]   inc_full;
    logic signed [tcf_pkg::CX_W-1:0]     ax_ext, dx, dy;
    logic signed [tcf_pkg::Z_W-1:0]      atan_val, ang_round;
    logic signed [tcf_pkg::ACCU_W-1:0]   blend_sh;
    logic signed [tcf_pkg::ROLL_W-1:0]   roll_sat;
    logic signed [tcf_pkg::ROLL_W:0]     roll_ext, band_pos, band_neg;
    logic                                above, below, enable;
    logic [tcf_pkg::SPEED_W-1:0]         speed_lim, speed;
    logic                                out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Shared multiplier operand selection
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_SQY:
            begin
                mul_a = {{A_EXT{ay_reg[tcf_pkg::ACCEL_W-1]}}, ay_reg};
                mul_b = {ay_reg[tcf_pkg::ACCEL_W-1], ay_reg};
            end
            S_SQZ:
            begin
                mul_a = {{A_EXT{az_reg[tcf_pkg::ACCEL_W-1]}}, az_reg};
                mul_b = {az_reg[tcf_pkg::ACCEL_W-1], az_reg};
            end
            S_RATE:
            begin
                mul_a = {{(tcf_pkg::MUL_A_W-tcf_pkg::GYRO_W){gyro_reg[tcf_pkg::GYRO_W-1]}},
                         gyro_reg};
                mul_b = {1'b0, time_step_reg};
            end
            S_GMUL:
            begin
                mul_a = gyro_roll_reg;
                mul_b = {1'b0, gyro_weight_reg};
            end
            S_AMUL:
            begin
                mul_a = {{(tcf_pkg::MUL_A_W-tcf_pkg::Z_W){acc_roll_reg[tcf_pkg::Z_W-1]}},
                         acc_roll_reg};
                mul_b = {1'b0, accel_weight_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = mul_en ? (mul_a * mul_b) : prod_reg;
    assign prod_ext  = {{(tcf_pkg::ACCU_W-tcf_pkg::PROD_W){prod_reg[tcf_pkg::PROD_W-1]}},
                        prod_reg};
    assign sq_sum    = acc_reg + prod_ext;

    // Gyro increment, rounded half up
    assign inc_full  = (prod_reg + tcf_pkg::GYRO_HALF) >>> tcf_pkg::GYRO_SHIFT;

    // Square root trial subtraction
    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};

    // CORDIC shifts and angle lookup
    assign ax_ext    = {{(tcf_pkg::CX_W-tcf_pkg::ACCEL_W){ax_reg[tcf_pkg::ACCEL_W-1]}}, ax_reg};
    assign dx        = cy_reg >>> cnt_reg;
    assign dy        = cx_reg >>> cnt_reg;
    assign atan_val  = tcf_pkg::atan_deg_q16(tcf_pkg::ATAN_IDX_W'(cnt_reg));
    assign ang_round = (cz_reg + tcf_pkg::ANG_HALF) >>> tcf_pkg::ANG_SHIFT;

    // Blend scaling, saturation and dead band
    assign blend_sh  = acc_reg >>> tcf_pkg::BLEND_SHIFT;
    always_comb
    begin
        if (blend_sh > $signed({{(tcf_pkg::ACCU_W-tcf_pkg::ROLL_W){1'b0}}, tcf_pkg::ROLL_MAX}))
        begin
            roll_sat = tcf_pkg::ROLL_MAX;
        end
        else if (blend_sh < $signed({{(tcf_pkg::ACCU_W-tcf_pkg::ROLL_W){1'b1}},
                                     tcf_pkg::ROLL_MIN}))
        begin
            roll_sat = tcf_pkg::ROLL_MIN;
        end
        else
        begin
            roll_sat = blend_sh[tcf_pkg::ROLL_W-1:0];
        end
    end

    assign roll_ext  = {roll_sat[tcf_pkg::ROLL_W-1], roll_sat};
    assign band_pos  = {{(tcf_pkg::ROLL_W+1-tcf_pkg::BAND_W){1'b0}}, dead_band_reg};
    assign band_neg  = -band_pos;
    assign above     = roll_ext > band_pos;
    assign below     = roll_ext < band_neg;
    assign enable    = above || below;
    assign speed_lim = (drive_speed_reg > tcf_pkg::SPEED_MAX) ? tcf_pkg::SPEED_MAX
                                                              : drive_speed_reg;
    assign speed     = enable ? speed_lim : '0;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        roll_est_next  = roll_est_reg;
        dir_next       = dir_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        zero_next      = zero_reg;
        gyro_roll_next = gyro_roll_reg;
        acc_roll_next  = acc_roll_reg;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                acc_next   = prod_ext;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                rad_next   = {sq_sum[tcf_pkg::SQ_W-1:0], 16'b0};
                root_next  = '0;
                bit_next   = tcf_pkg::ROOT_BIT0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (rad_reg >= trial[tcf_pkg::RAD_W-1:0])
                begin
                    rad_next  = rad_reg - trial[tcf_pkg::RAD_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                // The root is below 2^24, so it enters as a positive x.
                cx_next        = root_reg[tcf_pkg::CX_W-1:0];
                cy_next        = (tcf_pkg::CX_W'(0) - ax_ext) <<< 8;
                cz_next        = '0;
                zero_next      = (root_reg == '0) && (ax_reg == '0);
                gyro_roll_next = {{(tcf_pkg::MUL_A_W-tcf_pkg::ROLL_W){roll_est_reg[tcf_pkg::ROLL_W-1]}},
                                  roll_est_reg} + inc_full[tcf_pkg::MUL_A_W-1:0];
                cnt_next       = '0;
                state_next     = S_CORD;
            end
            S_CORD:
            begin
                // Vectoring: rotate toward y = 0, negative when y is not negative.
                if (!cy_reg[tcf_pkg::CX_W-1])
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_val;
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_val;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_GMUL;
                end
            end
            S_GMUL:
            begin
                // With no acceleration at all the accelerometer roll is zero.
                acc_roll_next = zero_reg ? '0 : ang_round;
                state_next    = S_AMUL;
            end
            S_AMUL:
            begin
                acc_next   = prod_ext;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next   = acc_reg + prod_ext + tcf_pkg::BLEND_HALF;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (out_free)
                begin
                    roll_est_next  = roll_sat;
                    if (above)
                    begin
                        dir_next = 1'b1;
                    end
                    else if (below)
                    begin
                        dir_next = 1'b0;
                    end
                    out_data_next  = {2'b00, speed, (above || (dir_reg && !below)),
                                      enable, roll_sat};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            roll_est_reg     <= '0;
            dir_reg          <= 1'b0;
            gyro_weight_reg  <= tcf_pkg::GYRO_WEIGHT_RST;
            accel_weight_reg <= tcf_pkg::ACCEL_WEIGHT_RST;
            time_step_reg    <= tcf_pkg::TIME_STEP_RST;
            dead_band_reg    <= tcf_pkg::DEAD_BAND_RST;
            drive_speed_reg  <= tcf_pkg::DRIVE_SPEED_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            roll_est_reg  <= roll_est_next;
            dir_reg       <= dir_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tcf_pkg::REG_GYRO_WEIGHT:  gyro_weight_reg  <= cfg_data[tcf_pkg::WEIGHT_W-1:0];
                    tcf_pkg::REG_ACCEL_WEIGHT: accel_weight_reg <= cfg_data[tcf_pkg::WEIGHT_W-1:0];
                    tcf_pkg::REG_TIME_STEP:    time_step_reg    <= cfg_data[tcf_pkg::WEIGHT_W-1:0];
                    tcf_pkg::REG_DEAD_BAND:    dead_band_reg    <= cfg_data[tcf_pkg::BAND_W-1:0];
                    tcf_pkg::REG_DRIVE_SPEED:  drive_speed_reg  <= cfg_data[tcf_pkg::SPEED_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            gyro_reg <= s_tdata[16:0];
            ax_reg   <= s_tdata[32:17];
            ay_reg   <= s_tdata[48:33];
            az_reg   <= s_tdata[64:49];
        end
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        zero_reg      <= zero_next;
        gyro_roll_reg <= gyro_roll_next;
        acc_roll_reg  <= acc_roll_next;
        out_data_reg  <= out_data_next;
    end

    // A sample beat starts the sequence, so the core stops taking beats.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core still ready after taking a sample beat");

    // During the square root the trial bit is a single bit.
    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> $onehot(bit_reg))
        else $error("square root trial bit is not one-hot");

    // The CORDIC step counter never passes the last step.
    a_cordic_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORD) |-> (cnt_reg <= tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1)))
        else $error("CORDIC step counter out of range");

    // A finished result waits while the output register is still full.
    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAT && out_valid_reg && !m_tready) |=>
        (state_reg == S_SAT && $stable(roll_est_reg)))
        else $error("result overwrote a beat not yet taken");

    // A stopped motor always reports zero speed.
    a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[21]) |-> (out_data_reg[29:23] == '0))
        else $error("motor speed given while motor is stopped");

endmodule

/* verif/tilt_complementary_filter_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tilt_complementary_filter_core: sends IMU sample beats and
// register writes, predicts every roll and motor decision, and checks each result beat.
// Depends on tcf_pkg and the core RTL.

module tilt_complementary_filter_core_test;

    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 205;
    localparam int RANDOM_PHASES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int ANGLE_STEPS   = 24;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [tcf_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [tcf_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct {
        logic signed [tcf_pkg::GYRO_W-1:0]  gyro_rate;
        logic signed [tcf_pkg::ACCEL_W-1:0] accel_x;
        logic signed [tcf_pkg::ACCEL_W-1:0] accel_y;
        logic signed [tcf_pkg::ACCEL_W-1:0] accel_z;
    } imu_sample_t;

    typedef struct {
        logic signed [tcf_pkg::ROLL_W-1:0] roll_angle;
        logic                              motor_enable;
        logic                              direction_forward;
        logic [tcf_pkg::SPEED_W-1:0]       motor_speed;
    } drive_decision_t;

    typedef enum {SHAPE_FULL, SHAPE_SMALL, SHAPE_LEVEL, SHAPE_AXIS_ZERO} sample_shape_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [tcf_pkg::IN_DATA_W-1:0]     s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [tcf_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [tcf_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    // Predictor copy of the registers and the filter state
    logic [tcf_pkg::WEIGHT_W-1:0]      gyro_weight_q16  = tcf_pkg::GYRO_WEIGHT_RST;
    logic [tcf_pkg::WEIGHT_W-1:0]      accel_weight_q16 = tcf_pkg::ACCEL_WEIGHT_RST;
    logic [tcf_pkg::WEIGHT_W-1:0]      time_step_q16    = tcf_pkg::TIME_STEP_RST;
    logic [tcf_pkg::BAND_W-1:0]        dead_band_level  = tcf_pkg::DEAD_BAND_RST;
    logic [tcf_pkg::SPEED_W-1:0]       drive_speed_pct  = tcf_pkg::DRIVE_SPEED_RST;
    logic signed [tcf_pkg::ROLL_W-1:0] roll_estimate    = '0;
    logic                              held_forward     = 1'b0;

    // atan(2^-i) in degrees with 16 fraction bits, rounded
    longint cordic_angle_q16 [0:ANGLE_STEPS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    drive_decision_t pending_decisions [$];

    logic steady_flow      = 1'b0;
    int   mismatch_count   = 0;
    int   samples_sent     = 0;
    int   results_seen     = 0;
    int   enabled_seen     = 0;
    int   forward_seen     = 0;
    int   saturated_seen   = 0;
    int   settings_applied = 0;

    tilt_complementary_filter_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint round_half_up(input longint value, input int shift);
        return (value + (longint'(1) <<< (shift - 1))) >>> shift;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned step_bit;
        longint unsigned rest;
        root     = 0;
        rest     = radicand;
        step_bit = 64'd1 << 62;
        while (step_bit > rest)
            step_bit = step_bit >> 2;
        while (step_bit != 0)
        begin
            if (rest >= root + step_bit)
            begin
                rest = rest - (root + step_bit);
                root = (root >> 1) + step_bit;
            end
            else
            begin
                root = root >> 1;
            end
            step_bit = step_bit >> 2;
        end
        return root;
    endfunction

    // Accelerometer roll in degrees with 16 fraction bits, by vectoring CORDIC.
    function automatic longint accel_roll_q16(input imu_sample_t reading);
        longint          ay;
        longint          az;
        longint          vx;
        longint          vy;
        longint          angle;
        longint          dx;
        longint          dy;
        longint unsigned sum_sq;
        int              i;
        ay     = longint'(reading.accel_y);
        az     = longint'(reading.accel_z);
        sum_sq = ay * ay + az * az;
        vx     = longint'(int_sqrt(sum_sq << 16));
        vy     = -longint'(reading.accel_x) * 256;
        angle  = 0;
        if (vx == 0 && vy == 0)
            return 0;
        for (i = 0; i < tcf_pkg::CORDIC_STEPS && i < ANGLE_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx    = vx + dx;
                vy    = vy - dy;
                angle = angle + cordic_angle_q16[i];
            end
            else
            begin
                vx    = vx - dx;
                vy    = vy + dy;
                angle = angle - cordic_angle_q16[i];
            end
        end
        return angle;
    endfunction

    // Advances the filter state by one sample and returns the decision it gives.
    function automatic drive_decision_t next_decision(input imu_sample_t reading);
        drive_decision_t outcome;
        longint          gyro_roll;
        longint          accel_roll;
        longint          blended;
        longint          band;
        gyro_roll  = longint'(roll_estimate)
                   + round_half_up(longint'(reading.gyro_rate) * longint'(time_step_q16),
                                   24 - tcf_pkg::ROLL_FRAC_BITS);
        accel_roll = round_half_up(accel_roll_q16(reading), 16 - tcf_pkg::ROLL_FRAC_BITS);
        blended    = (gyro_roll * longint'(gyro_weight_q16)
                   + accel_roll * longint'(accel_weight_q16) + 32768) >>> 16;
        if (blended > longint'(tcf_pkg::ROLL_MAX))
            blended = longint'(tcf_pkg::ROLL_MAX);
        else if (blended < longint'(tcf_pkg::ROLL_MIN))
            blended = longint'(tcf_pkg::ROLL_MIN);
        roll_estimate = blended[tcf_pkg::ROLL_W-1:0];

        band                 = longint'(dead_band_level);
        outcome.roll_angle   = roll_estimate;
        outcome.motor_enable = 1'b0;
        if (blended > band)
        begin
            outcome.motor_enable = 1'b1;
            held_forward         = 1'b1;
        end
        else if (blended < -band)
        begin
            outcome.motor_enable = 1'b1;
            held_forward         = 1'b0;
        end
        outcome.direction_forward = held_forward;
        if (!outcome.motor_enable)
            outcome.motor_speed = '0;
        else if (drive_speed_pct > tcf_pkg::SPEED_MAX)
            outcome.motor_speed = tcf_pkg::SPEED_MAX;
        else
            outcome.motor_speed = drive_speed_pct;
        return outcome;
    endfunction

    function automatic imu_sample_t make_sample(input int gyro, input int ax, input int ay,
                                                input int az);
        imu_sample_t reading;
        reading.gyro_rate = tcf_pkg::GYRO_W'(gyro);
        reading.accel_x   = tcf_pkg::ACCEL_W'(ax);
        reading.accel_y   = tcf_pkg::ACCEL_W'(ay);
        reading.accel_z   = tcf_pkg::ACCEL_W'(az);
        return reading;
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t   reading;
        sample_shape_t shape;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 55)
            shape = SHAPE_FULL;
        else if (pick < 70)
            shape = SHAPE_SMALL;
        else if (pick < 90)
            shape = SHAPE_LEVEL;
        else
            shape = SHAPE_AXIS_ZERO;
        reading.gyro_rate = tcf_pkg::GYRO_W'($urandom);
        reading.accel_x   = tcf_pkg::ACCEL_W'($urandom);
        reading.accel_y   = tcf_pkg::ACCEL_W'($urandom);
        reading.accel_z   = tcf_pkg::ACCEL_W'($urandom);
        case (shape)
            SHAPE_SMALL:
            begin
                reading.gyro_rate = tcf_pkg::GYRO_W'($urandom_range(511) - 256);
                reading.accel_x   = tcf_pkg::ACCEL_W'($urandom_range(63) - 32);
                reading.accel_y   = tcf_pkg::ACCEL_W'($urandom_range(63) - 32);
                reading.accel_z   = tcf_pkg::ACCEL_W'($urandom_range(63) - 32);
            end
            SHAPE_LEVEL:
            begin
                // A board near upright: gravity mostly on z, a modest tilt on x.
                reading.gyro_rate = tcf_pkg::GYRO_W'($urandom_range(8191) - 4096);
                reading.accel_x   = tcf_pkg::ACCEL_W'($urandom_range(16383) - 8192);
                reading.accel_y   = tcf_pkg::ACCEL_W'($urandom_range(1023) - 512);
                reading.accel_z   = tcf_pkg::ACCEL_W'($urandom_range(1)
                                        ? $urandom_range(20000, 12000)
                                        : -$urandom_range(20000, 12000));
            end
            SHAPE_AXIS_ZERO:
            begin
                if ($urandom_range(1))
                    reading.accel_y = '0;
                else
                    reading.accel_z = '0;
                if ($urandom_range(2) == 0)
                begin
                    reading.accel_y = '0;
                    reading.accel_z = '0;
                    if ($urandom_range(1))
                        reading.accel_x = '0;
                end
            end
            default:
            begin
            end
        endcase
        return reading;
    endfunction

    // The valid stays high after a beat; an idle cycle or a pause lowers it first.
    task automatic send_sample(input imu_sample_t reading);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 8)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tcf_pkg::IN_DATA_W'({reading.accel_z, reading.accel_y,
                                          reading.accel_x, reading.gyro_rate});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_decisions.push_back(next_decision(reading));
        samples_sent++;
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_for_idle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [tcf_pkg::CFG_IDX_W-1:0]  reg_index,
                                  input logic [tcf_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= reg_index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_index)
            tcf_pkg::REG_GYRO_WEIGHT:  gyro_weight_q16  = value[tcf_pkg::WEIGHT_W-1:0];
            tcf_pkg::REG_ACCEL_WEIGHT: accel_weight_q16 = value[tcf_pkg::WEIGHT_W-1:0];
            tcf_pkg::REG_TIME_STEP:    time_step_q16    = value[tcf_pkg::WEIGHT_W-1:0];
            tcf_pkg::REG_DEAD_BAND:    dead_band_level  = value[tcf_pkg::BAND_W-1:0];
            tcf_pkg::REG_DRIVE_SPEED:  drive_speed_pct  = value[tcf_pkg::SPEED_W-1:0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Unused upper data bits carry junk so that the register widths are checked too.
    task automatic apply_settings(input logic [15:0] gyro_w, input logic [15:0] accel_w,
                                  input logic [15:0] step, input logic [19:0] band,
                                  input logic [6:0] speed);
        wait_for_idle();
        write_register(tcf_pkg::REG_GYRO_WEIGHT,  {4'($urandom), gyro_w});
        write_register(tcf_pkg::REG_ACCEL_WEIGHT, {4'($urandom), accel_w});
        write_register(tcf_pkg::REG_TIME_STEP,    {4'($urandom), step});
        write_register(tcf_pkg::REG_DEAD_BAND,    band);
        write_register(tcf_pkg::REG_DRIVE_SPEED,  {13'($urandom), speed});
        settings_applied++;
    endtask

    task automatic test_reset_settings();
        steady_flow = 1'b1;
        send_sample(make_sample(0, 0, 0, 0));
        // Gravity along x alone: the accelerometer roll lands near minus or plus ninety degrees.
        send_sample(make_sample(0, 32767, 0, 0));
        send_sample(make_sample(0, -32768, 0, 0));
        send_sample(make_sample(65535, 32767, 32767, 32767));
        send_sample(make_sample(-65536, -32768, -32768, -32768));
        send_sample(make_sample(-65536, 0, 0, 16384));
    endtask

    task automatic test_register_corners();
        int spare;
        steady_flow = 1'b0;
        // No time step: the gyro rate must not move the roll.
        apply_settings(16'hFFFF, 16'h0000, 16'h0000, 20'd0, 7'd127);
        send_sample(make_sample(65535, 100, 200, 300));
        send_sample(make_sample(-65536, -100, 200, -300));

        // Full-scale weights and time step drive the roll into saturation, low first then high.
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd0, 7'd101);
        repeat (3) send_sample(make_sample(-65536, 32767, 0, 0));
        repeat (3) send_sample(make_sample(65535, -32768, 0, 0));

        // Widest band: the saturated roll decays inside it and the direction is held.
        apply_settings(16'hFFFF, 16'h0000, 16'h0001, 20'hFFFFF, 7'd100);
        repeat (2) send_sample(make_sample(0, 0, 0, 0));

        wait_for_idle();
        for (spare = int'(REG_SPARE_FIRST); spare <= int'(REG_SPARE_LAST); spare++)
            write_register(tcf_pkg::CFG_IDX_W'(spare), 20'hFFFFF);
        send_sample(make_sample(-4096, 0, 0, 16384));
        send_sample(make_sample(4096, 0, 0, -16384));

        // Accel roll alone, with a zero speed while the motor is enabled.
        apply_settings(16'h0000, 16'hFFFF, 16'd655, 20'd0, 7'd0);
        send_sample(make_sample(0, 16384, 0, 16384));
        send_sample(make_sample(0, -16384, 16384, 0));
        send_sample(make_sample(0, 0, -32768, 0));
        send_sample(make_sample(0, 1, 0, 0));
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        logic [15:0] gyro_w;
        logic [15:0] accel_w;
        logic [15:0] step;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: apply_settings(tcf_pkg::GYRO_WEIGHT_RST, tcf_pkg::ACCEL_WEIGHT_RST,
                                  tcf_pkg::TIME_STEP_RST, tcf_pkg::DEAD_BAND_RST,
                                  tcf_pkg::DRIVE_SPEED_RST);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 7'd127);
                2: apply_settings(16'h0000, 16'h0000, 16'h0001, 20'd0, 7'd100);
                default:
                begin
                    gyro_w = 16'($urandom_range(65535));
                    // Mostly weights that add up to about one, as the filter is meant.
                    if ($urandom_range(3) == 0)
                        accel_w = 16'($urandom_range(65535));
                    else
                        accel_w = (gyro_w == 0) ? 16'hFFFF : 16'(65536 - gyro_w);
                    step = $urandom_range(3) == 0 ? 16'($urandom_range(65535, 1))
                                                  : 16'($urandom_range(2000, 1));
                    apply_settings(gyro_w, accel_w, step, 20'($urandom_range(32768)),
                                   7'($urandom_range(127)));
                end
            endcase
            steady_flow = (phase == 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(63) == 0)
                    pause_until_drained();
                send_sample(random_sample());
            end
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        drive_decision_t got;
        drive_decision_t want;
        if (m_tvalid && m_tready)
        begin
            got.roll_angle        = m_tdata[tcf_pkg::ROLL_W-1:0];
            got.motor_enable      = m_tdata[tcf_pkg::ROLL_W];
            got.direction_forward = m_tdata[tcf_pkg::ROLL_W+1];
            got.motor_speed       = m_tdata[tcf_pkg::ROLL_W+2 +: tcf_pkg::SPEED_W];
            results_seen++;
            if (pending_decisions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result beat %0d with nothing expected: roll %0d",
                             results_seen, got.roll_angle);
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (got.roll_angle !== want.roll_angle
                    || got.motor_enable !== want.motor_enable
                    || got.direction_forward !== want.direction_forward
                    || got.motor_speed !== want.motor_speed)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("beat %0d roll/en/fwd/speed: expected %0d/%0b/%0b/%0d, got %0d/%0b/%0b/%0d",
                                 results_seen, want.roll_angle, want.motor_enable,
                                 want.direction_forward, want.motor_speed,
                                 got.roll_angle, got.motor_enable,
                                 got.direction_forward, got.motor_speed);
                end
                if (want.motor_enable)
                    enabled_seen++;
                if (want.motor_enable && want.direction_forward)
                    forward_seen++;
                if (want.roll_angle == tcf_pkg::ROLL_MAX || want.roll_angle == tcf_pkg::ROLL_MIN)
                    saturated_seen++;
            end
        end
        m_tready <= steady_flow || ($urandom_range(99) >= 8);
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no beat for %0d cycles", STALL_LIMIT);
        $display("tilt_complementary_filter_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_register_corners();
        test_random_traffic();
        wait_for_idle();
        $display("Checked %0d results from %0d samples under %0d register settings.",
                 results_seen, samples_sent, settings_applied);
        $display("Motor ran on %0d results (%0d forward), roll at a rail on %0d; %0d bad.",
                 enabled_seen, forward_seen, saturated_seen, mismatch_count);
        if (mismatch_count == 0 && pending_decisions.size() == 0)
            $display("tilt_complementary_filter_core: match");
        else
            $display("tilt_complementary_filter_core: mismatch");
        $finish;
    end

endmodule
